@@ rtl/core/assert_macros.svh @@
// Assertion macros used by gsp_checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition implies another on the same edge.
`define ASSERT_IMPLY(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

`endif

@@ rtl/core/gsp_pkg.sv @@
// Package for the gamepad serial poll master: state types, codes, frame tables.
// Used by every module of the block; depends on nothing.
package gsp_pkg;

	localparam int IN_W  = 8;
	localparam int OUT_W = 56;

	localparam logic [1:0] OP_CONFIG   = 2'd1;
	localparam logic [1:0] OP_POLL     = 2'd2;
	localparam logic [1:0] KIND_CONFIG = 2'd1;
	localparam logic [1:0] KIND_POLL   = 2'd2;

	localparam logic [1:0] REG_HALF_BIT  = 2'd0;
	localparam logic [1:0] REG_FRAME_GAP = 2'd1;

	localparam logic [7:0]  HALF_BIT_RESET  = 8'd50;
	localparam logic [15:0] FRAME_GAP_RESET = 16'd6000;

	localparam logic [7:0] BYTE_START = 8'h01;
	localparam logic [7:0] BYTE_POLL  = 8'h42;
	localparam logic [7:0] ID_ANALOG  = 8'h73;
	localparam logic [1:0] LAST_FRAME = 2'd2;

	localparam logic [7:0] CFG_FRAMES [3][9] = '{
		'{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}
	};

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_LOW  = 5'b00010,
		PH_HIGH = 5'b00100,
		PH_ACK  = 5'b01000,
		PH_GAP  = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  kind;
		logic [1:0]  frame;
		logic [3:0]  byte_idx;
		logic [2:0]  bit_idx;
		logic [7:0]  half_cnt;
		logic [15:0] gap_cnt;
		logic [7:0]  shift_out;
		logic [7:0]  shift_in;
		logic [15:0] buttons;
		logic [31:0] sticks;   // right_x, right_y, left_x, left_y from bit 0 up
		logic        clk_pin;
		logic        cmd_pin;
		logic        att_pin;
	} state_t;

	// idle phase, everything else zero; phase sits in the top bits
	localparam state_t STATE_RESET = state_t'({PH_IDLE,
		{($bits(state_t) - $bits(phase_t)){1'b0}}});

	typedef struct packed {
		logic [7:0]  half_bit;
		logic [15:0] frame_gap;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic ok;
	} flags_t;

	function automatic logic [7:0] byte_value(logic [1:0] kind, logic [1:0] frame,
			logic [3:0] idx);
		logic [1:0] f;
		f = (frame > LAST_FRAME) ? LAST_FRAME : frame;
		if (kind == KIND_CONFIG) begin
			return (idx < 4'd9) ? CFG_FRAMES[f][idx] : 8'h00;
		end
		if (idx == 4'd0) return BYTE_START;
		if (idx == 4'd1) return BYTE_POLL;
		return 8'h00;
	endfunction

	function automatic logic [4:0] frame_len(logic [1:0] kind, logic [1:0] frame);
		if (kind == KIND_CONFIG && frame == 2'd0) return 5'd5;
		return 5'd9;
	endfunction

	// Load the byte at byte_idx and begin its first low clock half.
	function automatic state_t start_byte(state_t s);
		state_t n;
		n           = s;
		n.shift_out = byte_value(s.kind, s.frame, s.byte_idx);
		n.bit_idx   = '0;
		n.half_cnt  = 8'd1;
		n.cmd_pin   = n.shift_out[0];
		n.clk_pin   = 1'b0;
		n.att_pin   = 1'b0;
		n.phase     = PH_LOW;
		return n;
	endfunction

	function automatic state_t finish(state_t s);
		state_t n;
		n         = s;
		n.phase   = PH_IDLE;
		n.att_pin = 1'b1;
		if (s.kind == KIND_POLL) n.cmd_pin = 1'b1;
		return n;
	endfunction

endpackage

@@ rtl/core/gamepad_serial_poll_master.sv @@
// Top level of the gamepad serial poll master.
// Depends on gsp_pkg, gsp_step and gsp_out_reg.
//
// Each input item is one time tick: opcode (idle, configure, poll) plus the
// sampled data and acknowledge pins. Each accepted item yields exactly one
// result item: the pin levels to drive, busy/done/poll_ok status and the last
// stored button and stick bytes.
// Latency: the result for an item is valid on the cycle after it is accepted.
// Throughput: one item per clock cycle while the receiver does not stall; the
// state update is a single registered pass through the tick logic.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready: index 0 sets half_bit_ticks from cfg_data[7:0], index 1 sets
// frame_gap_ticks; other indexes are ignored. Write only while idle.
// Reset: phase idle, all pins low, stored values zero, half_bit_ticks 50,
// frame_gap_ticks 6000, no result held.
// Receiver stall: the result stays in the output register; s_tready follows
// the free space there, so a new item is taken in the same cycle the held one
// leaves, and input is held off while the receiver stalls.
module gamepad_serial_poll_master (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [gsp_pkg::IN_W-1:0]  s_tdata,  // opcode[1:0], data_pin, ack_pin, zeros
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// clock_pin, command_pin, attention_pin, busy_res, done_res, poll_ok,
	// buttons[15:0], right_x, right_y, left_x, left_y, zeros
	output logic [gsp_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data
);

	gsp_pkg::state_t st_q;
	gsp_pkg::state_t st_nxt;
	gsp_pkg::cfg_t   cfg_q;
	gsp_pkg::flags_t flags;
	logic            accept;
	logic [gsp_pkg::OUT_W-1:0] res;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit  <= gsp_pkg::HALF_BIT_RESET;
			cfg_q.frame_gap <= gsp_pkg::FRAME_GAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				gsp_pkg::REG_HALF_BIT:  cfg_q.half_bit  <= cfg_data[7:0];
				gsp_pkg::REG_FRAME_GAP: cfg_q.frame_gap <= cfg_data;
				default: ;
			endcase
		end
	end

	gsp_step u_step (
		.st       (st_q),
		.cfg      (cfg_q),
		.opcode   (s_tdata[1:0]),
		.data_pin (s_tdata[2]),
		.ack_pin  (s_tdata[3]),
		.nxt      (st_nxt),
		.flags    (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gsp_pkg::STATE_RESET;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	assign res = {2'b00, st_nxt.sticks, st_nxt.buttons, flags.ok, flags.done,
		st_nxt.phase != gsp_pkg::PH_IDLE, st_nxt.att_pin, st_nxt.cmd_pin,
		st_nxt.clk_pin};

	gsp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.din      (res),
		.space    (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ rtl/core/gsp_step.sv @@
// Next-state and result logic for one tick of the gamepad serial poll master.
// Purely combinational; uses gsp_pkg for the state type and frame tables.
module gsp_step (
	input  gsp_pkg::state_t st,
	input  gsp_pkg::cfg_t   cfg,
	input  logic [1:0]      opcode,
	input  logic            data_pin,
	input  logic            ack_pin,
	output gsp_pkg::state_t nxt,
	output gsp_pkg::flags_t flags
);

	logic [7:0] h;
	logic       id_bad;

	assign h = (cfg.half_bit == 8'd0) ? 8'd1 : cfg.half_bit;
	assign id_bad = (st.kind == gsp_pkg::KIND_POLL) && (st.byte_idx == 4'd1)
		&& (st.shift_in != gsp_pkg::ID_ANALOG);

	always_comb begin
		gsp_pkg::state_t n;
		n          = st;
		flags.done = 1'b0;
		flags.ok   = 1'b0;
		case (st.phase)
			gsp_pkg::PH_IDLE: begin
				if (opcode == gsp_pkg::OP_CONFIG || opcode == gsp_pkg::OP_POLL) begin
					n.kind     = opcode;
					n.frame    = '0;
					n.byte_idx = '0;
					n = gsp_pkg::start_byte(n);
				end
			end
			gsp_pkg::PH_LOW: begin
				if (st.half_cnt >= h) begin
					n.shift_in = {data_pin, st.shift_in[7:1]};
					n.clk_pin  = 1'b1;
					n.half_cnt = 8'd1;
					n.phase    = gsp_pkg::PH_HIGH;
				end else begin
					n.half_cnt = st.half_cnt + 8'd1;
				end
			end
			gsp_pkg::PH_HIGH: begin
				if (st.half_cnt < h) begin
					n.half_cnt = st.half_cnt + 8'd1;
				end else if (st.bit_idx < 3'd7) begin
					n.bit_idx   = st.bit_idx + 3'd1;
					n.shift_out = {1'b0, st.shift_out[7:1]};
					n.cmd_pin   = st.shift_out[1];
					n.clk_pin   = 1'b0;
					n.half_cnt  = 8'd1;
					n.phase     = gsp_pkg::PH_LOW;
				end else begin
					// byte complete: store reply bytes of a poll
					if (st.kind == gsp_pkg::KIND_POLL) begin
						case (st.byte_idx)
							4'd3: n.buttons[7:0]   = st.shift_in;
							4'd4: n.buttons[15:8]  = st.shift_in;
							4'd5: n.sticks[7:0]    = st.shift_in;
							4'd6: n.sticks[15:8]   = st.shift_in;
							4'd7: n.sticks[23:16]  = st.shift_in;
							4'd8: n.sticks[31:24]  = st.shift_in;
							default: ;
						endcase
					end
					if ({1'b0, st.byte_idx} + 5'd1 >= gsp_pkg::frame_len(st.kind, st.frame))
					begin
						if (st.kind == gsp_pkg::KIND_CONFIG) begin
							n.att_pin = 1'b1;
							n.gap_cnt = '0;
							n.phase   = gsp_pkg::PH_GAP;
						end else begin
							n        = gsp_pkg::finish(n);
							flags.done = 1'b1;
							flags.ok   = 1'b1;
						end
					end else if (ack_pin) begin
						if (id_bad) begin
							n          = gsp_pkg::finish(n);
							flags.done = 1'b1;
						end else begin
							n.byte_idx = st.byte_idx + 4'd1;
							n = gsp_pkg::start_byte(n);
						end
					end else begin
						n.phase = gsp_pkg::PH_ACK;
					end
				end
			end
			gsp_pkg::PH_ACK: begin
				if (ack_pin) begin
					if (id_bad) begin
						n          = gsp_pkg::finish(n);
						flags.done = 1'b1;
					end else begin
						n.byte_idx = st.byte_idx + 4'd1;
						n = gsp_pkg::start_byte(n);
					end
				end
			end
			gsp_pkg::PH_GAP: begin
				if (st.gap_cnt < cfg.frame_gap) begin
					n.gap_cnt = st.gap_cnt + 16'd1;
				end else if (st.frame < gsp_pkg::LAST_FRAME) begin
					n.frame    = st.frame + 2'd1;
					n.byte_idx = '0;
					n = gsp_pkg::start_byte(n);
				end else begin
					n          = gsp_pkg::finish(n);
					flags.done = 1'b1;
				end
			end
			default: n.phase = gsp_pkg::PH_IDLE;
		endcase
		nxt = n;
	end

endmodule

@@ rtl/core/gsp_out_reg.sv @@
// Output register of the gamepad serial poll master: holds one result item
// until the receiver takes it. Uses gsp_pkg for the item width.
module gsp_out_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  logic [gsp_pkg::OUT_W-1:0] din,
	output logic                      space,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [gsp_pkg::OUT_W-1:0] m_tdata
);

	logic                      valid_q;
	logic [gsp_pkg::OUT_W-1:0] data_q;

	// free when empty or when the held item leaves on this edge
	assign space    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= din;
		end
	end

endmodule

@@ rtl/core/gsp_checker.sv @@
// Port-level checks for the gamepad serial poll master, bound to the top level.
// Uses the macros of assert_macros.svh and the widths of gsp_pkg.
`include "assert_macros.svh"

module gsp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [gsp_pkg::OUT_W-1:0] m_tdata
);

	// a stalled result item holds
	`ASSERT_CLK(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	// an empty output stage never refuses an item
	`ASSERT_IMPLY(a_ready, !m_tvalid, s_tready, "input refused with empty output stage")
	// the done tick ends the operation
	`ASSERT_IMPLY(a_done_idle, m_tvalid && m_tdata[4], !m_tdata[3] && m_tdata[2], "done while busy or attention low")
	// poll_ok only comes with done
	`ASSERT_IMPLY(a_ok_done, m_tvalid && m_tdata[5], m_tdata[4], "poll_ok without done")

endmodule

bind gamepad_serial_poll_master gsp_checker u_gsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ dv/gamepad_serial_poll_master_checker.sv @@
// Checker for the gamepad serial poll master: watches the tick, result and register channels.
// Holds its own tick-by-tick model of the link timing and compares every result item.
// Depends on gsp_pkg for the phase type and the operation and register codes.
module gamepad_serial_poll_master_checker
	import gsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [OUT_W-1:0]  m_tdata,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// one result item, first member in the top bits as on m_tdata
	typedef struct packed {
		logic [7:0]  left_y;
		logic [7:0]  left_x;
		logic [7:0]  right_y;
		logic [7:0]  right_x;
		logic [15:0] buttons;
		logic        poll_ok;
		logic        done;
		logic        busy;
		logic        att_lvl;
		logic        cmd_lvl;
		logic        clk_lvl;
	} pad_result_t;

	// setup frames, byte k of frame f at bits (9f+k)*8, first byte lowest
	localparam logic [215:0] SETUP_BYTES = {
		72'h5A_5A_5A_5A_5A_00_00_43_01,
		72'h00_00_00_00_03_01_00_44_01,
		72'h00_00_00_00_00_01_00_43_01
	};
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [7:0] READ_BYTE  = 8'h42;

	logic [7:0]  half_bit_cfg;
	logic [15:0] gap_cfg;

	phase_t      stage;
	logic [1:0]  op_kind;
	logic [1:0]  frame_no;
	logic [3:0]  byte_no;
	logic [2:0]  bit_no;
	logic [7:0]  half_cnt;
	logic [15:0] gap_cnt;
	logic [7:0]  tx_byte;
	logic [7:0]  rx_byte;
	logic [15:0] btn;
	logic [7:0]  stick_rx, stick_ry, stick_lx, stick_ly;
	logic        clk_lvl, cmd_lvl, att_lvl;
	logic        done_now, ok_now;

	pad_result_t ticks_due[$];
	pad_result_t want, got;

	task automatic load_byte();
		if (op_kind == KIND_CONFIG)
			tx_byte = (byte_no < 4'd9) ? SETUP_BYTES[(int'(frame_no) * 9 + int'(byte_no)) * 8 +: 8]
				: 8'h00;
		else if (byte_no == 4'd0)
			tx_byte = START_BYTE;
		else if (byte_no == 4'd1)
			tx_byte = READ_BYTE;
		else
			tx_byte = 8'h00;
		bit_no   = '0;
		half_cnt = 8'd1;
		cmd_lvl  = tx_byte[0];
		clk_lvl  = 1'b0;
		att_lvl  = 1'b0;
		stage    = PH_LOW;
	endtask

	task automatic end_op(input logic ok);
		stage   = PH_IDLE;
		att_lvl = 1'b1;
		if (op_kind == KIND_POLL)
			cmd_lvl = 1'b1;
		done_now = 1'b1;
		ok_now   = ok;
	endtask

	// a wrong identity ends the poll once the second byte is acknowledged
	task automatic advance_byte();
		if (op_kind == KIND_POLL && byte_no == 4'd1 && rx_byte != ID_ANALOG) begin
			end_op(1'b0);
		end else begin
			byte_no = byte_no + 4'd1;
			load_byte();
		end
	endtask

	task automatic predict_tick(input logic [1:0] op, input logic dpin, input logic apin);
		logic [7:0] h;
		int         frame_bytes;
		pad_result_t r;
		h        = (half_bit_cfg == 8'd0) ? 8'd1 : half_bit_cfg;
		done_now = 1'b0;
		ok_now   = 1'b0;
		case (stage)
			PH_IDLE: begin
				if (op == OP_CONFIG || op == OP_POLL) begin
					op_kind  = op;
					frame_no = '0;
					byte_no  = '0;
					load_byte();
				end
			end
			PH_LOW: begin
				if (half_cnt >= h) begin
					rx_byte  = {dpin, rx_byte[7:1]};
					clk_lvl  = 1'b1;
					half_cnt = 8'd1;
					stage    = PH_HIGH;
				end else begin
					half_cnt = half_cnt + 8'd1;
				end
			end
			PH_HIGH: begin
				if (half_cnt < h) begin
					half_cnt = half_cnt + 8'd1;
				end else if (bit_no < 3'd7) begin
					bit_no   = bit_no + 3'd1;
					tx_byte  = tx_byte >> 1;
					cmd_lvl  = tx_byte[0];
					clk_lvl  = 1'b0;
					half_cnt = 8'd1;
					stage    = PH_LOW;
				end else begin
					// byte complete: poll replies land as each byte ends
					if (op_kind == KIND_POLL) begin
						case (byte_no)
							4'd3: btn[7:0]  = rx_byte;
							4'd4: btn[15:8] = rx_byte;
							4'd5: stick_rx  = rx_byte;
							4'd6: stick_ry  = rx_byte;
							4'd7: stick_lx  = rx_byte;
							4'd8: stick_ly  = rx_byte;
							default: ;
						endcase
					end
					frame_bytes = (op_kind == KIND_CONFIG && frame_no == 2'd0) ? 5 : 9;
					if (int'(byte_no) + 1 >= frame_bytes) begin
						if (op_kind == KIND_CONFIG) begin
							att_lvl = 1'b1;
							gap_cnt = '0;
							stage   = PH_GAP;
						end else begin
							end_op(1'b1);
						end
					end else if (apin) begin
						advance_byte();
					end else begin
						stage = PH_ACK;
					end
				end
			end
			PH_ACK: begin
				if (apin)
					advance_byte();
			end
			PH_GAP: begin
				if (gap_cnt < gap_cfg) begin
					gap_cnt = gap_cnt + 16'd1;
				end else if (frame_no < 2'd2) begin
					frame_no = frame_no + 2'd1;
					byte_no  = '0;
					load_byte();
				end else begin
					end_op(1'b0);
				end
			end
			default: stage = PH_IDLE;
		endcase
		r.clk_lvl = clk_lvl;
		r.cmd_lvl = cmd_lvl;
		r.att_lvl = att_lvl;
		r.busy    = (stage != PH_IDLE);
		r.done    = done_now;
		r.poll_ok = ok_now;
		r.buttons = btn;
		r.right_x = stick_rx;
		r.right_y = stick_ry;
		r.left_x  = stick_lx;
		r.left_y  = stick_ly;
		ticks_due.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_cfg = HALF_BIT_RESET;
			gap_cfg      = FRAME_GAP_RESET;
			stage        = PH_IDLE;
			op_kind      = '0;
			frame_no     = '0;
			byte_no      = '0;
			bit_no       = '0;
			half_cnt     = '0;
			gap_cnt      = '0;
			tx_byte      = '0;
			rx_byte      = '0;
			btn          = '0;
			stick_rx     = '0;
			stick_ry     = '0;
			stick_lx     = '0;
			stick_ly     = '0;
			clk_lvl      = 1'b0;
			cmd_lvl      = 1'b0;
			att_lvl      = 1'b0;
			mismatches   = 0;
			ticks_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HALF_BIT:  half_bit_cfg = cfg_data[7:0];
					REG_FRAME_GAP: gap_cfg = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (ticks_due.size() == 0) begin
					$error("result item with nothing expected: %0h", m_tdata);
					mismatches++;
				end else begin
					want = ticks_due.pop_front();
					got  = pad_result_t'(m_tdata[53:0]);
					check_field("clock_pin", 16'(want.clk_lvl), 16'(got.clk_lvl));
					check_field("command_pin", 16'(want.cmd_lvl), 16'(got.cmd_lvl));
					check_field("attention_pin", 16'(want.att_lvl), 16'(got.att_lvl));
					check_field("busy_res", 16'(want.busy), 16'(got.busy));
					check_field("done_res", 16'(want.done), 16'(got.done));
					check_field("poll_ok", 16'(want.poll_ok), 16'(got.poll_ok));
					check_field("buttons", want.buttons, got.buttons);
					check_field("right_x", 16'(want.right_x), 16'(got.right_x));
					check_field("right_y", 16'(want.right_y), 16'(got.right_y));
					check_field("left_x", 16'(want.left_x), 16'(got.left_x));
					check_field("left_y", 16'(want.left_y), 16'(got.left_y));
				end
			end
			if (s_tvalid && s_tready)
				predict_tick(s_tdata[1:0], s_tdata[2], s_tdata[3]);
		end
		pending <= ticks_due.size();
	end

endmodule

@@ dv/gamepad_serial_poll_master_tb.sv @@
// Top of the gamepad serial poll master testbench: clock, reset, tick stimulus and verdict.
// Drives timed poll and setup sequences; gamepad_serial_poll_master_checker does the checking.
// Depends on gsp_pkg, the block and the checker.
module gamepad_serial_poll_master_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gsp_pkg::*;

	localparam logic [1:0] OP_IDLE  = 2'd0;
	localparam logic [1:0] OP_SPARE = 2'd3;	// decodes as idle
	localparam logic [1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;
	localparam int LONG_STALL = 400;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;

	int  mismatches;
	int  pending;
	int  half_eff;
	int  gap_now;
	int  ticks_sent;
	bit  in_idle_on;
	bit  out_idle_on;
	bit  long_stall_due;

	gamepad_serial_poll_master i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gamepad_serial_poll_master_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic put_tick(input logic [1:0] op, input logic dpin, input logic apin);
		int unsigned pause;
		pause = in_idle_on ? $urandom_range(13, 0) : 0;
		if (pause != 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, apin, dpin, op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		ticks_sent++;
	endtask

	// one byte on the wire: data held for the whole bit, so the sample tick sees it
	task automatic send_byte(input logic [1:0] first_op, input logic [7:0] reply);
		int span;
		span = 2 * half_eff;
		for (int t = 0; t < 8 * span; t++) begin
			if (t == 0)
				put_tick(first_op, reply[0], 1'b1);
			else
				put_tick(2'($urandom_range(3, 0)), reply[t / span], 1'($urandom_range(1, 0)));
		end
	endtask

	// controller late with its acknowledge now and then
	task automatic ack_wait();
		int unsigned w;
		w = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0;
		repeat (w) put_tick(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), 1'b0);
	endtask

	task automatic idle_gap();
		repeat ($urandom_range(3, 0))
			put_tick($urandom_range(1, 0) ? OP_IDLE : OP_SPARE, 1'($urandom_range(1, 0)),
				1'($urandom_range(1, 0)));
	endtask

	task automatic run_poll(input logic [7:0] id, input logic [55:0] tail);
		send_byte(OP_POLL, 8'($urandom));
		ack_wait();
		send_byte(2'($urandom_range(3, 0)), id);
		if (id == ID_ANALOG) begin
			for (int k = 0; k < 7; k++) begin
				ack_wait();
				send_byte(2'($urandom_range(3, 0)), tail[8 * k +: 8]);
			end
			put_tick(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
		end else begin
			ack_wait();
			put_tick(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), 1'b1);
		end
	endtask

	task automatic run_configure();
		int n;
		for (int f = 0; f < 3; f++) begin
			n = (f == 0) ? 5 : 9;
			for (int k = 0; k < n; k++) begin
				if (k > 0)
					ack_wait();
				send_byte((f == 0 && k == 0) ? OP_CONFIG : 2'($urandom_range(3, 0)), 8'($urandom));
			end
			// frame end tick, then the gap with attention high
			repeat (gap_now + 1)
				put_tick(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)),
					1'($urandom_range(1, 0)));
		end
		put_tick(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_HALF_BIT)
			half_eff = (value[7:0] == 8'd0) ? 1 : int'(value[7:0]);
		else if (idx == REG_FRAME_GAP)
			gap_now = int'(value);
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [7:0] half, input logic [15:0] gap);
		wait_idle();
		write_reg(REG_HALF_BIT, {8'($urandom), half});
		write_reg(REG_FRAME_GAP, gap);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int unsigned hold;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_stall_due) begin
				hold = LONG_STALL;
				long_stall_due = 1'b0;
			end else begin
				hold = out_idle_on ? $urandom_range(13, 0) : 0;
			end
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		int random_start;
		int unsigned pick;
		logic [7:0] half;
		logic [15:0] gap;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_idle_on     = 1'b0;
		out_idle_on    = 1'b0;
		long_stall_due = 1'b0;
		half_eff       = int'(HALF_BIT_RESET);
		gap_now        = int'(FRAME_GAP_RESET);
		ticks_sent     = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset levels and spare opcode while idle
		put_tick(OP_IDLE, 1'b0, 1'b0);
		put_tick(OP_SPARE, 1'b1, 1'b1);
		put_tick(OP_IDLE, 1'b1, 1'b0);
		put_tick(OP_SPARE, 1'b0, 1'b1);

		// zero half bit and no frame gap
		set_timing(8'd0, 16'd0);
		write_reg(REG_UNMAPPED_LO, 16'($urandom));
		write_reg(REG_UNMAPPED_HI, 16'($urandom));
		in_idle_on  = 1'b1;
		out_idle_on = 1'b1;
		run_configure();
		idle_gap();
		run_poll(ID_ANALOG, '0);
		run_poll(8'h41, 56'({$urandom, $urandom}));
		put_tick(OP_IDLE, 1'b1, 1'b1);
		run_poll(8'hFF, 56'({$urandom, $urandom}));
		run_poll(ID_ANALOG, '1);

		random_start = ticks_sent;
		while (ticks_sent < 1000) begin
			case ($urandom_range(5, 0))
				0:       half = 8'd0;
				4:       half = 8'd2;
				5:       half = 8'd3;
				default: half = 8'd1;
			endcase
			gap = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(40, 5))
				: 16'($urandom_range(4, 0));
			set_timing(half, gap);
			in_idle_on  = ($urandom_range(3, 0) != 0);
			out_idle_on = ($urandom_range(3, 0) != 0);
			if (ticks_sent == random_start)
				long_stall_due = 1'b1;
			repeat ($urandom_range(4, 2)) begin
				pick = $urandom_range(9, 0);
				if (pick < 6)
					run_poll(ID_ANALOG, 56'({$urandom, $urandom}));
				else if (pick < 8)
					run_poll(8'($urandom), 56'({$urandom, $urandom}));
				else
					run_configure();
				idle_gap();
			end
		end

		wait_idle();
		repeat (3) @(posedge clk);
		if (mismatches == 0)
			$display("gamepad_serial_poll_master test passed");
		else
			$display("gamepad_serial_poll_master test failed");
		$finish;
	end

	initial begin
		#30ms;
		$display("gamepad_serial_poll_master test failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/gsp_pkg.sv
rtl/core/gsp_step.sv
rtl/core/gsp_out_reg.sv
rtl/core/gamepad_serial_poll_master.sv
rtl/core/gsp_checker.sv
dv/gamepad_serial_poll_master_checker.sv
dv/gamepad_serial_poll_master_tb.sv
